FILE: hw/rtl/lfc_pkg.sv
// Shared constants, types and the exp table builder for the film compositor.
package lfc_pkg;

	localparam int TransFracBits = 15;
	localparam int ExpEntries    = 256;
	localparam int ExpIdxW       = $clog2(ExpEntries);
	localparam int RomAddrW      = $clog2(ExpEntries + 1);
	localparam int TransW        = TransFracBits + 1;
	localparam int ExpW          = 48;
	localparam int ExpLimitBit   = 32;
	localparam int AccW          = TransFracBits + 9;
	localparam int MulW          = 32;

	localparam logic [TransW-1:0] OneT = {1'b1, {TransFracBits{1'b0}}};

	localparam logic [2:0] CompCuIO   = 3'd0;
	localparam logic [2:0] CompCuIIO  = 3'd1;
	localparam logic [2:0] CompCuSO4  = 3'd2;
	localparam logic [2:0] CompCsa    = 3'd3;
	localparam logic [2:0] CompCustom = 3'd4;

	// coefficient magnitudes, Q4.12
	localparam logic [15:0] CoefAMag = 16'd2130;
	localparam logic [15:0] CoefBMag = 16'd18842;

	localparam logic [7:0]  ByteMax       = 8'd255;
	localparam logic [23:0] DepthMax      = 24'hFFFFFF;
	localparam logic [23:0] DepthXLimit   = 24'd12800;
	localparam logic [MulW-1:0] DepthRecip = 32'd20972;
	localparam int DepthRecipShift = 20;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PROD, ST_SPREAD, ST_TD, ST_TR, ST_TM, ST_W,
		ST_C0, ST_C1, ST_C2, ST_L, ST_R1, ST_R2, ST_M1, ST_M2,
		ST_F0, ST_F1, ST_F2, ST_FR, ST_FM, ST_FD1, ST_FD2, ST_DONE
	} step_t;

	typedef struct packed {
		logic [2:0]  composition;
		logic [15:0] absorption_coeff;
		logic [15:0] thickness;
		logic [15:0] diffuse_spread;
		logic [23:0] layer_color_rgb;
		logic [8:0]  layer_roughness;
		logic [8:0]  layer_metallic;
		logic        layer_disturb;
		logic        last_layer;
		logic [23:0] back_color_rgb;
		logic [8:0]  base_roughness;
		logic [8:0]  base_metallic;
	} item_t;

	typedef struct packed {
		step_t step;
		logic  load;
	} ctrl_t;

	typedef struct packed {
		logic [23:0] rgb;
		logic [7:0]  rough;
		logic [7:0]  metal;
		logic        disturb;
		logic [7:0]  depth;
	} result_t;

	// shift and subtract quotient, evaluated while the table is elaborated
	function automatic longint unsigned const_udiv(input longint unsigned n,
			input longint unsigned d);
		longint unsigned q, r;
		q = 64'd0;
		r = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			r = (r << 1) | ((n >> b) & 64'd1);
			if (r >= d) begin
				r = r - d;
				q = q | (64'd1 << b);
			end
		end
		return q;
	endfunction

	// exp(-16 i / N) in Q1.F, built from a Q58 series and repeated products
	function automatic logic [TransW-1:0] exp_entry(input int unsigned idx);
		longint unsigned term, sum, p, m, ah, al, bh, bl, mid;
		int unsigned k, j;
		term = 64'd1 << 58;
		sum  = term;
		p    = term;
		m    = (64'd1 << 29) - 64'd1;
		for (k = 1; k <= 40; k++) begin
			if (term != 0) begin
				term = const_udiv(term * 64'd16, 64'(ExpEntries) * 64'(k));
				if ((k & 1) != 0) sum = sum - term;
				else sum = sum + term;
			end
		end
		for (j = 0; j < idx; j++) begin
			ah  = p >> 29;
			al  = p & m;
			bh  = sum >> 29;
			bl  = sum & m;
			mid = ah * bl + al * bh + ((al * bl) >> 29);
			p   = ah * bh + (mid >> 29);
		end
		return TransW'((p + (64'd1 << (57 - TransFracBits))) >> (58 - TransFracBits));
	endfunction

endpackage

FILE: hw/rtl/lfc_exp_rom.sv
// Exp table and interpolation operand lookup.
module lfc_exp_rom import lfc_pkg::*; (
	input  logic [ExpW-1:0]   e,
	output logic [TransW-1:0] hi,
	output logic [TransW-1:0] lo,
	output logic [MulW-1:0]   frac,
	output logic              over
);

	logic [TransW-1:0] rom_w [ExpEntries+1];
	logic [ExpIdxW-1:0] idx;
	logic [RomAddrW-1:0] addr_hi, addr_lo;

	for (genvar gi = 0; gi <= ExpEntries; gi++) begin : g_rom
		localparam logic [TransW-1:0] Val = exp_entry(gi);
		assign rom_w[gi] = Val;
	end

	assign over    = |e[ExpW-1:ExpLimitBit];
	assign idx     = e[ExpLimitBit-1 -: ExpIdxW];
	assign frac    = {e[ExpLimitBit-ExpIdxW-1:0], {ExpIdxW{1'b0}}};
	assign addr_hi = RomAddrW'(idx);
	assign addr_lo = addr_hi + 1'b1;
	assign hi      = rom_w[addr_hi];
	assign lo      = rom_w[addr_lo];

endmodule

FILE: hw/rtl/lfc_dp.sv
// Layer datapath: pixel state and the shared multiplier, stepped by the sequencer.
module lfc_dp import lfc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  ctrl_t   ctrl,
	input  item_t   item,
	output result_t res
);

	item_t it_q;
	logic open_q;
	logic [31:0] p_q;
	logic [ExpW-1:0] ed_q;
	logic [TransW-1:0] td_q, tr_q, tm_q, w_q, light_q;
	logic [AccW-1:0] acc_q [3];
	logic [AccW-1:0] rough_q, metal_q, tmp_q;
	logic dist_q;
	logic [23:0] depth_q, x_q;
	logic [23:0] rgb_q;
	logic [7:0] rres_q, mres_q, dres_q;

	logic coef_neg;
	logic [15:0] coef_mag;
	logic [MulW-1:0] ma, mb;
	logic [2*MulW-1:0] prod;
	logic [ExpW-1:0] e_sel, er, em;
	logic [TransW-1:0] rom_hi, rom_lo, t_calc;
	logic [MulW-1:0] rom_frac;
	logic rom_over;
	logic [7:0] col_ch, back_ch;
	logic [AccW:0] fin;
	logic [24:0] dsum;
	logic [23:0] dbase;

	always_comb begin
		coef_neg = 1'b0;
		coef_mag = '0;
		case (it_q.composition)
			CompCuIO: begin
				coef_neg = 1'b1;
				coef_mag = CoefAMag;
			end
			CompCuSO4: begin
				coef_neg = 1'b1;
				coef_mag = CoefBMag;
			end
			CompCustom: begin
				coef_neg = it_q.absorption_coeff[15];
				coef_mag = ~it_q.absorption_coeff + 16'd1;
			end
			default: ;
		endcase
	end

	assign em = ExpW'(p_q) << 8;
	assign er = (ExpW'(p_q) << 11) + (ExpW'(p_q) << 9);

	always_comb begin
		case (ctrl.step)
			ST_TR:   e_sel = er;
			ST_TM:   e_sel = em;
			default: e_sel = ed_q;
		endcase
	end

	lfc_exp_rom u_rom (
		.e    (e_sel),
		.hi   (rom_hi),
		.lo   (rom_lo),
		.frac (rom_frac),
		.over (rom_over)
	);

	always_comb begin
		case (ctrl.step)
			ST_C0, ST_F0: begin
				col_ch  = it_q.layer_color_rgb[23:16];
				back_ch = it_q.back_color_rgb[23:16];
			end
			ST_C1, ST_F1: begin
				col_ch  = it_q.layer_color_rgb[15:8];
				back_ch = it_q.back_color_rgb[15:8];
			end
			default: begin
				col_ch  = it_q.layer_color_rgb[7:0];
				back_ch = it_q.back_color_rgb[7:0];
			end
		endcase
	end

	// operand select for the one shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (ctrl.step)
			ST_PROD: begin
				ma = MulW'(coef_mag);
				mb = MulW'(it_q.thickness);
			end
			ST_SPREAD: begin
				ma = p_q;
				mb = MulW'(it_q.diffuse_spread);
			end
			ST_TD, ST_TR, ST_TM: begin
				ma = MulW'(rom_hi - rom_lo);
				mb = rom_frac;
			end
			ST_W: begin
				ma = MulW'(OneT - td_q);
				mb = MulW'(light_q);
			end
			ST_C0, ST_C1, ST_C2: begin
				ma = MulW'(col_ch);
				mb = MulW'(w_q);
			end
			ST_L: begin
				ma = MulW'(light_q);
				mb = MulW'(td_q);
			end
			ST_R1: begin
				ma = MulW'(rough_q);
				mb = MulW'(tr_q);
			end
			ST_R2: begin
				ma = MulW'(it_q.layer_roughness);
				mb = MulW'(OneT - tr_q);
			end
			ST_M1: begin
				ma = MulW'(metal_q);
				mb = MulW'(tm_q);
			end
			ST_M2: begin
				ma = MulW'(it_q.layer_metallic);
				mb = MulW'(OneT - tm_q);
			end
			ST_F0, ST_F1, ST_F2: begin
				ma = MulW'(back_ch);
				mb = MulW'(light_q);
			end
			ST_FR: begin
				ma = MulW'(rough_q);
				mb = MulW'(ByteMax);
			end
			ST_FM: begin
				ma = MulW'(metal_q);
				mb = MulW'(ByteMax);
			end
			ST_FD1: begin
				ma = MulW'(depth_q);
				mb = MulW'(ByteMax);
			end
			ST_FD2: begin
				ma = MulW'(x_q);
				mb = DepthRecip;
			end
			default: ;
		endcase
	end

	assign prod = ma * mb;

	always_comb begin
		if (!coef_neg) t_calc = OneT;
		else if (rom_over) t_calc = '0;
		else t_calc = rom_hi - prod[ExpLimitBit +: TransW];
	end

	always_comb begin
		case (ctrl.step)
			ST_F0:   fin = (AccW+1)'(acc_q[0]) + (AccW+1)'(prod);
			ST_F1:   fin = (AccW+1)'(acc_q[1]) + (AccW+1)'(prod);
			default: fin = (AccW+1)'(acc_q[2]) + (AccW+1)'(prod);
		endcase
	end

	assign dbase = open_q ? depth_q : '0;
	assign dsum  = {1'b0, dbase} + 25'(item.thickness);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (ctrl.load) begin
			open_q <= ~item.last_layer;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			it_q    <= item;
			dist_q  <= (open_q & dist_q) | item.layer_disturb;
			depth_q <= dsum[24] ? DepthMax : dsum[23:0];
			if (!open_q) begin
				acc_q[0] <= '0;
				acc_q[1] <= '0;
				acc_q[2] <= '0;
				light_q  <= OneT;
				rough_q  <= AccW'(item.base_roughness) << TransFracBits;
				metal_q  <= AccW'(item.base_metallic) << TransFracBits;
			end
		end else begin
			case (ctrl.step)
				ST_PROD:   p_q <= prod[31:0];
				ST_SPREAD: ed_q <= (it_q.composition == CompCustom) ? prod[ExpW-1:0] : em;
				ST_TD:     td_q <= t_calc;
				ST_TR:     tr_q <= t_calc;
				ST_TM:     tm_q <= t_calc;
				ST_W:      w_q <= prod[TransFracBits +: TransW];
				ST_C0:     acc_q[0] <= acc_q[0] + prod[AccW-1:0];
				ST_C1:     acc_q[1] <= acc_q[1] + prod[AccW-1:0];
				ST_C2:     acc_q[2] <= acc_q[2] + prod[AccW-1:0];
				ST_L:      light_q <= prod[TransFracBits +: TransW];
				ST_R1:     tmp_q <= prod[TransFracBits +: AccW];
				ST_R2:     rough_q <= tmp_q + prod[AccW-1:0];
				ST_M1:     tmp_q <= prod[TransFracBits +: AccW];
				ST_M2:     metal_q <= tmp_q + prod[AccW-1:0];
				ST_F0:     rgb_q[23:16] <= (|fin[AccW:TransFracBits+8]) ? ByteMax
						: fin[TransFracBits +: 8];
				ST_F1:     rgb_q[15:8] <= (|fin[AccW:TransFracBits+8]) ? ByteMax
						: fin[TransFracBits +: 8];
				ST_F2:     rgb_q[7:0] <= (|fin[AccW:TransFracBits+8]) ? ByteMax
						: fin[TransFracBits +: 8];
				ST_FR:     rres_q <= (|prod[2*MulW-1:TransFracBits+16]) ? ByteMax
						: prod[TransFracBits+8 +: 8];
				ST_FM:     mres_q <= (|prod[2*MulW-1:TransFracBits+16]) ? ByteMax
						: prod[TransFracBits+8 +: 8];
				ST_FD1:    x_q <= prod[31:8];
				ST_FD2:    dres_q <= (x_q >= DepthXLimit) ? ByteMax
						: prod[DepthRecipShift +: 8];
				default: ;
			endcase
		end
	end

	assign res.rgb     = rgb_q;
	assign res.rough   = rres_q;
	assign res.metal   = mres_q;
	assign res.disturb = dist_q;
	assign res.depth   = dres_q;

endmodule

FILE: hw/rtl/layered_film_compositor.sv
// Top level: layer item intake, sequencer and output register of the film compositor.
// Result: an item with last_layer set raises out_valid once DONE hands its result over.
// Every item runs the per layer steps and a closing item the final steps as well; one
//   shared multiplier is stepped through every product and table interpolation.
// The input is stalled whenever the sequencer is not idle.
// Reset (arst_n low) clears sequencer, output valid and the open pixel flag.
module layered_film_compositor import lfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  composition,
	input  logic [15:0] absorption_coeff,
	input  logic [15:0] thickness,
	input  logic [15:0] diffuse_spread,
	input  logic [23:0] layer_color_rgb,
	input  logic [8:0]  layer_roughness,
	input  logic [8:0]  layer_metallic,
	input  logic        layer_disturb,
	input  logic        last_layer,
	input  logic [23:0] back_color_rgb,
	input  logic [8:0]  base_roughness,
	input  logic [8:0]  base_metallic,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] diffuse_rgb,
	output logic [7:0]  roughness_byte,
	output logic [7:0]  metallic_byte,
	output logic        disturb,
	output logic [7:0]  depth_byte
);

	step_t state_q, state_d;
	logic last_q;
	logic in_xfer, out_load;
	item_t item;
	ctrl_t ctrl;
	result_t res;
	logic out_valid_q;
	result_t out_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid & ~in_stall;

	assign item = '{composition: composition, absorption_coeff: absorption_coeff,
		thickness: thickness, diffuse_spread: diffuse_spread,
		layer_color_rgb: layer_color_rgb, layer_roughness: layer_roughness,
		layer_metallic: layer_metallic, layer_disturb: layer_disturb,
		last_layer: last_layer, back_color_rgb: back_color_rgb,
		base_roughness: base_roughness, base_metallic: base_metallic};

	// sequencer: per layer product, spread, three transmittances, weight, colour,
	// light, roughness and metallic; closing items then run the final steps
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_PROD;
			ST_PROD:   state_d = ST_SPREAD;
			ST_SPREAD: state_d = ST_TD;
			ST_TD:     state_d = ST_TR;
			ST_TR:     state_d = ST_TM;
			ST_TM:     state_d = ST_W;
			ST_W:      state_d = ST_C0;
			ST_C0:     state_d = ST_C1;
			ST_C1:     state_d = ST_C2;
			ST_C2:     state_d = ST_L;
			ST_L:      state_d = ST_R1;
			ST_R1:     state_d = ST_R2;
			ST_R2:     state_d = ST_M1;
			ST_M1:     state_d = ST_M2;
			ST_M2:     state_d = last_q ? ST_F0 : ST_IDLE;
			ST_F0:     state_d = ST_F1;
			ST_F1:     state_d = ST_F2;
			ST_F2:     state_d = ST_FR;
			ST_FR:     state_d = ST_FM;
			ST_FM:     state_d = ST_FD1;
			ST_FD1:    state_d = ST_FD2;
			ST_FD2:    state_d = ST_DONE;
			ST_DONE: begin
				// hand over once the output register is free or draining
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) last_q <= last_layer;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= res;
	end

	assign ctrl.step = state_q;
	assign ctrl.load = in_xfer;

	lfc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.item   (item),
		.res    (res)
	);

	assign out_valid      = out_valid_q;
	assign diffuse_rgb    = out_q.rgb;
	assign roughness_byte = out_q.rough;
	assign metallic_byte  = out_q.metal;
	assign disturb        = out_q.disturb;
	assign depth_byte     = out_q.depth;

endmodule

FILE: hw/rtl/lfc_checker.sv
// Port level checks for the film compositor, bound to the top level.
module lfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [23:0] diffuse_rgb,
	input logic [7:0]  roughness_byte,
	input logic [7:0]  metallic_byte
);

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(diffuse_rgb) && $stable(roughness_byte)
			&& $stable(metallic_byte))
		else $error("output payload changed while stalled");

endmodule

bind layered_film_compositor lfc_checker u_lfc_checker (.*);
